/* sv/radix_integer_text_parser_macros.svh */
// Assertion macros used by the parser's top-level RTL file
`ifndef RADIX_INTEGER_TEXT_PARSER_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RITP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radix parser check failed");

// next-cycle implication, checked out of reset
`define RITP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radix parser check failed");

`endif

/* sv/ritp_pkg.sv */
// Package: types, codes and constants of the radix integer text parser
package ritp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               format_error;
  } out_word_t;

  localparam logic [1:0] OP_DIGIT = 2'd0;
  localparam logic [1:0] OP_NEG   = 2'd1;
  localparam logic [1:0] OP_POS   = 2'd2;
  localparam logic [1:0] OP_FAIL  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] digit;
    logic [5:0] radix;
    logic       wide_mode;
    logic       last_char;
  } ritp_entry_t;

  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic       WIDE_RESET  = 1'b1;
  localparam logic [5:0] DIGIT_NONE  = 6'd63;
  localparam logic [5:0] LETTER_BASE = 6'd10;

  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;

  localparam logic       REG_RADIX = 1'b0;
  localparam logic       REG_WIDE  = 1'b1;

  localparam int PROD_W = 70;
  localparam logic [PROD_W-1:0] LIM64_POS = {7'd0, {63{1'b1}}};
  localparam logic [PROD_W-1:0] LIM64_NEG = {6'd0, 1'b1, 63'd0};
  localparam logic [PROD_W-1:0] LIM32_POS = {39'd0, {31{1'b1}}};
  localparam logic [PROD_W-1:0] LIM32_NEG = {38'd0, 1'b1, 31'd0};

endpackage

/* sv/ritp_front.sv */
// Front end: accept characters, track the first character and classify each one
module ritp_front (
  input  logic              clk,
  input  logic              rst,
  input  ritp_pkg::in_word_t item,
  input  logic              accept,
  input  logic [5:0]        radix,
  input  logic              wide_mode,
  output ritp_pkg::ritp_entry_t entry
);

  logic       first;
  logic [5:0] dv;
  logic       radix_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (accept) begin
      first <= item.last_char;
    end
  end

  always_comb begin
    dv = ritp_pkg::DIGIT_NONE;
    if (item.char_code >= ritp_pkg::CH_ZERO && item.char_code <= ritp_pkg::CH_NINE) begin
      dv = 6'(item.char_code - ritp_pkg::CH_ZERO);
    end else if (item.char_code >= ritp_pkg::CH_LOWER_A &&
                 item.char_code <= ritp_pkg::CH_LOWER_Z) begin
      dv = 6'(item.char_code - ritp_pkg::CH_LOWER_A) + ritp_pkg::LETTER_BASE;
    end else if (item.char_code >= ritp_pkg::CH_UPPER_A &&
                 item.char_code <= ritp_pkg::CH_UPPER_Z) begin
      dv = 6'(item.char_code - ritp_pkg::CH_UPPER_A) + ritp_pkg::LETTER_BASE;
    end
  end

  assign radix_ok = (radix >= ritp_pkg::RADIX_MIN) && (radix <= ritp_pkg::RADIX_MAX);

  always_comb begin
    entry.digit     = dv;
    entry.radix     = radix;
    entry.wide_mode = wide_mode;
    entry.last_char = item.last_char;
    priority if (!radix_ok) begin
      entry.op = ritp_pkg::OP_FAIL;
    end else if (first && item.char_code < ritp_pkg::CH_ZERO) begin
      if (item.char_code == ritp_pkg::CH_MINUS) begin
        entry.op = ritp_pkg::OP_NEG;
      end else if (item.char_code == ritp_pkg::CH_PLUS) begin
        entry.op = ritp_pkg::OP_POS;
      end else begin
        entry.op = ritp_pkg::OP_FAIL;
      end
    end else if (dv < radix) begin
      entry.op = ritp_pkg::OP_DIGIT;
    end else begin
      entry.op = ritp_pkg::OP_FAIL;
    end
  end

endmodule

/* sv/ritp_queue.sv */
// Two-entry queue between the front end and the accumulator
module ritp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  ritp_pkg::ritp_entry_t wr_entry,
  input  logic                  rd_en,
  output ritp_pkg::ritp_entry_t rd_entry,
  output logic                  full,
  output logic                  empty
);

  ritp_pkg::ritp_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

  assign rd_entry = slots[rd_ptr];
  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);

endmodule

/* sv/ritp_back.sv */
// Back end: magnitude accumulation against a sign-dependent limit, overflow check and result register
module ritp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ritp_pkg::ritp_entry_t entry,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output ritp_pkg::out_word_t   result
);

  logic [63:0] mag;
  logic        neg;
  logic        seen;
  logic        failed;
  logic        res_valid;
  ritp_pkg::out_word_t res;

  logic [63:0] mag_next;
  logic        neg_next;
  logic        seen_next;
  logic        failed_next;
  logic [ritp_pkg::PROD_W-1:0] prod;
  logic [ritp_pkg::PROD_W-1:0] limit;
  logic        err;

  assign q_pop = !q_empty && (!entry.last_char || !res_valid || pop);

  always_comb begin
    prod = ritp_pkg::PROD_W'(mag) * ritp_pkg::PROD_W'(entry.radix)
         + ritp_pkg::PROD_W'(entry.digit);
    if (entry.wide_mode) begin
      limit = neg ? ritp_pkg::LIM64_NEG : ritp_pkg::LIM64_POS;
    end else begin
      limit = neg ? ritp_pkg::LIM32_NEG : ritp_pkg::LIM32_POS;
    end
  end

  always_comb begin
    mag_next    = mag;
    neg_next    = neg;
    seen_next   = seen;
    failed_next = failed;
    unique case (entry.op)
      ritp_pkg::OP_DIGIT: begin
        if (!failed) begin
          if (prod > limit) begin
            failed_next = 1'b1;
          end else begin
            mag_next  = prod[63:0];
            seen_next = 1'b1;
          end
        end
      end
      ritp_pkg::OP_NEG: begin
        neg_next = 1'b1;
      end
      ritp_pkg::OP_POS: begin
        neg_next = neg;
      end
      ritp_pkg::OP_FAIL: begin
        failed_next = 1'b1;
      end
    endcase
    err = failed_next || !seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag    <= 64'd0;
      neg    <= 1'b0;
      seen   <= 1'b0;
      failed <= 1'b0;
    end else if (q_pop) begin
      if (entry.last_char) begin
        mag    <= 64'd0;
        neg    <= 1'b0;
        seen   <= 1'b0;
        failed <= 1'b0;
      end else begin
        mag    <= mag_next;
        neg    <= neg_next;
        seen   <= seen_next;
        failed <= failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop && entry.last_char) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && entry.last_char) begin
      res.format_error <= err;
      if (err) begin
        res.value <= 64'sd0;
      end else begin
        res.value <= neg_next ? $signed(64'd0 - mag_next) : $signed(mag_next);
      end
    end
  end

  assign empty  = !res_valid;
  assign result = res;

endmodule

/* sv/radix_integer_text_parser.sv */
// Top level: radix integer text parser with APB configuration
// Parses one numeral given one character per word (last_char marks its end) in the
// configured radix (2 to 36) with an optional leading sign, using 32-bit or 64-bit
// signed limits, and yields one result word per numeral: the value, or format_error
// with value 0 for a bad character or radix, a lone sign or overflow. One character
// is taken every clock cycle while full is low; the accumulator's multiply-add and
// limit compare are combinational. A result passes through the queue into the output
// register, where it waits as characters flow in; the next last one waits for pop.
// Registers: radix at byte address 0 (reset 10), wide_mode at 4 (reset 1).
module radix_integer_text_parser (
  input  logic                clk,
  input  logic                rst,
  input  ritp_pkg::in_word_t  item,
  input  logic                push,
  output logic                full,
  output ritp_pkg::out_word_t result,
  output logic                empty,
  input  logic                pop,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  `include "radix_integer_text_parser_macros.svh"

  logic [5:0] radix;
  logic       wide_mode;
  logic       cfg_wr;
  logic       in_acc;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  ritp_pkg::ritp_entry_t f_entry;
  ritp_pkg::ritp_entry_t q_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= ritp_pkg::RADIX_RESET;
      wide_mode <= ritp_pkg::WIDE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ritp_pkg::REG_RADIX) begin
        radix <= pwdata[5:0];
      end else begin
        wide_mode <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == ritp_pkg::REG_WIDE) ? {31'd0, wide_mode} : {26'd0, radix};

  assign full   = q_full;
  assign in_acc = push && !q_full;

  ritp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .accept    (in_acc),
    .radix     (radix),
    .wide_mode (wide_mode),
    .entry     (f_entry)
  );

  ritp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_acc),
    .wr_entry (f_entry),
    .rd_en    (q_pop),
    .rd_entry (q_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  ritp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .entry   (q_entry),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  `RITP_ASSERT_NOW(a_err_zero, clk, rst, !empty && result.format_error, result.value == 64'sd0)
  `RITP_ASSERT_NEXT(a_push_lands, clk, rst, in_acc, !q_empty)
  `RITP_ASSERT_NOW(a_pop_needs_word, clk, rst, q_pop, !q_empty)

endmodule
